FILE: rtl/ilp_pkg.sv
// ----------------------------------------------------------------------------
// ilp_pkg: shared types and constants of the integer literal parser
// Parse modes, the control state passed between the datapath parts, and the
// ASCII codes the parser reacts to.
// ----------------------------------------------------------------------------
package ilp_pkg;

    typedef enum logic [7:0] {
        MODE_SPACE  = 8'b0000_0001,
        MODE_SIGNED = 8'b0000_0010,
        MODE_START  = 8'b0000_0100,
        MODE_ZERO   = 8'b0000_1000,
        MODE_OCT    = 8'b0001_0000,
        MODE_HEX    = 8'b0010_0000,
        MODE_DEC    = 8'b0100_0000,
        MODE_DONE   = 8'b1000_0000
    } t_mode;

    typedef struct packed {
        t_mode mode;
        logic  negative;
    } t_parse_ctl;

    localparam t_parse_ctl CTL_RESET = '{mode: MODE_SPACE, negative: 1'b0};

    localparam logic [7:0] CH_WS_LO = 8'd9;
    localparam logic [7:0] CH_WS_HI = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [3:0] HEX_LETTER_OFS = 4'd9;

endpackage

FILE: rtl/ilp_step.sv
// ----------------------------------------------------------------------------
// ilp_step: per-byte parse update
// Classifies one character and gives the next parse mode, sign flag and
// accumulator. Multiplies by the radix with shifts and adds.
// ----------------------------------------------------------------------------
module ilp_step #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic [7:0]             i_char,
    input  ilp_pkg::t_parse_ctl    i_ctl,
    input  logic [VALUE_WIDTH-1:0] i_acc,
    output ilp_pkg::t_parse_ctl    o_ctl,
    output logic [VALUE_WIDTH-1:0] o_acc
);
    import ilp_pkg::*;

    logic                   is_space;
    logic                   is_dec;
    logic                   is_oct;
    logic                   is_hex;
    logic [3:0]             digit;
    logic [VALUE_WIDTH-1:0] digit_ext;
    logic [VALUE_WIDTH-1:0] acc_oct;
    logic [VALUE_WIDTH-1:0] acc_dec;
    logic [VALUE_WIDTH-1:0] acc_hex;

    assign is_space = ((i_char >= CH_WS_LO) && (i_char <= CH_WS_HI)) || (i_char == CH_SPACE);
    assign is_dec   = (i_char >= CH_0) && (i_char <= CH_9);
    assign is_oct   = (i_char >= CH_0) && (i_char <= CH_7);
    assign is_hex   = is_dec || ((i_char >= CH_LA) && (i_char <= CH_LF))
                      || ((i_char >= CH_UA) && (i_char <= CH_UF));

    // low nibble is the digit for '0'..'9'; letters sit nine below their value
    assign digit     = is_dec ? i_char[3:0] : i_char[3:0] + HEX_LETTER_OFS;
    assign digit_ext = VALUE_WIDTH'(digit);

    assign acc_oct = (i_acc << 3) + digit_ext;
    assign acc_hex = (i_acc << 4) + digit_ext;
    assign acc_dec = (i_acc << 3) + (i_acc << 1) + digit_ext;

    always_comb begin
        o_ctl = i_ctl;
        o_acc = i_acc;
        case (i_ctl.mode)
            MODE_SPACE, MODE_SIGNED, MODE_START: begin
                if ((i_ctl.mode == MODE_SPACE) && is_space) begin
                    o_ctl.mode = MODE_SPACE;
                end else if ((i_ctl.mode == MODE_SPACE) && (i_char == CH_MINUS)) begin
                    o_ctl.mode     = MODE_SIGNED;
                    o_ctl.negative = 1'b1;
                end else if ((i_ctl.mode != MODE_START) && (i_char == CH_PLUS)) begin
                    o_ctl.mode = MODE_START;
                end else if (i_char == CH_0) begin
                    o_ctl.mode = MODE_ZERO;
                end else if (is_dec) begin
                    o_ctl.mode = MODE_DEC;
                    o_acc      = acc_dec;
                end else begin
                    o_ctl.mode = MODE_DONE;
                end
            end
            MODE_ZERO: begin
                if ((i_char == CH_LX) || (i_char == CH_UX)) begin
                    o_ctl.mode = MODE_HEX;
                end else if (is_oct) begin
                    o_ctl.mode = MODE_OCT;
                    o_acc      = acc_oct;
                end else begin
                    o_ctl.mode = MODE_DONE;
                end
            end
            MODE_OCT: begin
                if (is_oct) begin
                    o_acc = acc_oct;
                end else begin
                    o_ctl.mode = MODE_DONE;
                end
            end
            MODE_HEX: begin
                if (is_hex) begin
                    o_acc = acc_hex;
                end else begin
                    o_ctl.mode = MODE_DONE;
                end
            end
            MODE_DEC: begin
                if (is_dec) begin
                    o_acc = acc_dec;
                end else begin
                    o_ctl.mode = MODE_DONE;
                end
            end
            default: begin
                o_ctl.mode = MODE_DONE;
            end
        endcase
    end

endmodule

FILE: rtl/integer_literal_parser.sv
// ----------------------------------------------------------------------------
// integer_literal_parser: streaming C-style integer literal to binary
// Accepts one character per request and returns the signed value after the
// request marked last.
// ----------------------------------------------------------------------------
// Each character request is captured in an input register; the parse state
// and accumulator then update from it through a shift-and-add radix multiply
// (or reset after a last character), and the value of a finished literal is
// written into the output register as its last character leaves the input
// register, so a result passes the input and then the output register before
// it is offered. A new character is taken every cycle unless a last character
// waits in the input register while a previous result is still untaken.
// Leading whitespace, an optional '-' then '+', and the 0 / 0x prefixes are
// handled as in C; parsing stops at the first character that fits no digit
// and the value wraps modulo 2^VALUE_WIDTH, sign-extended or cut to the
// 32-bit result.
module integer_literal_parser #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // is_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // [31:0] value
);
    import ilp_pkg::*;

    logic                   r_in_valid;
    logic [7:0]             r_in_char;
    logic                   r_in_last;
    t_parse_ctl             r_ctl;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_out_valid;
    logic [31:0]            r_out_data;

    t_parse_ctl                    n_ctl;
    logic [VALUE_WIDTH-1:0]        n_acc;
    logic signed [VALUE_WIDTH-1:0] n_value;
    logic                          advance;

    ilp_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .i_char(r_in_char),
        .i_ctl (r_ctl),
        .i_acc (r_acc),
        .o_ctl (n_ctl),
        .o_acc (n_acc)
    );

    // a last character needs room in the output register
    assign advance       = r_in_valid && (!r_in_last || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign n_value       = n_ctl.negative ? -n_acc : n_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= CTL_RESET;
            r_acc <= '0;
        end else if (advance) begin
            // start the next literal fresh after the last character
            if (r_in_last) begin
                r_ctl <= CTL_RESET;
                r_acc <= '0;
            end else begin
                r_ctl <= n_ctl;
                r_acc <= n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_data <= 32'(n_value);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

FILE: tb/integer_literal_parser_tb.sv
// ----------------------------------------------------------------------------
// integer_literal_parser_tb: self-checking bench for the integer literal parser
// Streams text literals into the parser one character per request. A directed
// set covers signs, radix prefixes and odd terminators. Random literals follow,
// most of them well formed with random digits, with noise mixed in. Both
// stream sides idle at random. A value board predicts each parsed value and
// compares it with the result stream.
// ----------------------------------------------------------------------------
module integer_literal_parser_tb;
    import ilp_pkg::*;

    class value_board;
        t_mode       mode;
        logic [31:0] accum;
        logic        minus;
        logic [31:0] values_due[$];
        int          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            mode  = MODE_SPACE;
            accum = '0;
            minus = 1'b0;
        endfunction

        function int pending();
            return values_due.size();
        endfunction

        function int hex_digit(logic [7:0] c);
            if (c >= CH_0 && c <= CH_9) return c - CH_0;
            if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
            if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
            return -1;
        endfunction

        function void push_digit(int base, int d);
            accum = accum * base + d;
        endfunction

        // first character where a number may begin, after any sign
        function void begin_number(logic [7:0] c);
            if (c == CH_0) begin
                mode = MODE_ZERO;
            end else if (c > CH_0 && c <= CH_9) begin
                push_digit(10, c - CH_0);
                mode = MODE_DEC;
            end else begin
                mode = MODE_DONE;
            end
        endfunction

        function void take_char(logic [7:0] c, logic last);
            int h;
            h = hex_digit(c);
            case (mode)
                MODE_SPACE: begin
                    if ((c >= CH_WS_LO && c <= CH_WS_HI) || c == CH_SPACE) begin
                        mode = MODE_SPACE;
                    end else if (c == CH_MINUS) begin
                        minus = 1'b1;
                        mode  = MODE_SIGNED;
                    end else if (c == CH_PLUS) begin
                        mode = MODE_START;
                    end else begin
                        begin_number(c);
                    end
                end
                MODE_SIGNED: begin
                    if (c == CH_PLUS) mode = MODE_START;
                    else begin_number(c);
                end
                MODE_START: begin_number(c);
                MODE_ZERO: begin
                    if (c == CH_LX || c == CH_UX) begin
                        mode = MODE_HEX;
                    end else if (c >= CH_0 && c <= CH_7) begin
                        push_digit(8, c - CH_0);
                        mode = MODE_OCT;
                    end else begin
                        mode = MODE_DONE;
                    end
                end
                MODE_OCT: begin
                    if (c >= CH_0 && c <= CH_7) push_digit(8, c - CH_0);
                    else mode = MODE_DONE;
                end
                MODE_HEX: begin
                    if (h >= 0) push_digit(16, h);
                    else mode = MODE_DONE;
                end
                MODE_DEC: begin
                    if (c >= CH_0 && c <= CH_9) push_digit(10, c - CH_0);
                    else mode = MODE_DONE;
                end
                default: mode = MODE_DONE;
            endcase
            if (last) begin
                values_due.push_back(minus ? -accum : accum);
                clear();
            end
        endfunction

        function void check_value(logic [31:0] got);
            logic [31:0] want;
            if (values_due.size() == 0) begin
                $error("value: expected none, got %0d", $signed(got));
                errors++;
                return;
            end
            want = values_due.pop_front();
            if (got !== want) begin
                $error("value: expected %0d, got %0d", $signed(want), $signed(got));
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] char_in
    logic        s_axis_tlast = 1'b0; // is_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // [31:0] value

    value_board  board = new();
    logic [7:0]  text[$];
    bit          steady = 1'b0;
    int          chars_sent = 0;
    int          results_seen = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    integer_literal_parser dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) board.take_char(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) board.check_value(m_axis_tdata);
        end
    end

    // receiver: one long hold-off early on, a quiet stretch later, random stalls otherwise
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) results_seen++;
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 30) begin
            hold_done = 1'b1;
            hold_left = 300;
            m_axis_tready <= 1'b0;
        end else if (results_seen >= 100 && results_seen < 160) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= 26);
        end
    end

    task send_char(input logic [7:0] c, input logic last);
        int gap;
        // a random gap before about one request in six, unless steady is set
        if (!steady && $urandom_range(0, 99) < 18) begin
            gap = $urandom_range(1, 3);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        chars_sent++;
    endtask

    task send_literal();
        foreach (text[i]) send_char(text[i], i == text.size() - 1);
        text.delete();
    endtask

    task push_text(input string s);
        for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    endtask

    function logic [7:0] space_char();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : 8'(r);
    endfunction

    task make_literal();
        string hexset;
        int    n;
        hexset = "0123456789abcdefABCDEF";
        text.delete();
        if ($urandom_range(0, 99) < 12) begin
            n = $urandom_range(1, 8);
            repeat (n) text.push_back(8'($urandom_range(0, 255)));
            return;
        end
        n = $urandom_range(0, 2);
        repeat (n) text.push_back(space_char());
        case ($urandom_range(0, 9))
            0, 1: text.push_back(CH_MINUS);
            2: text.push_back(CH_PLUS);
            3: begin
                text.push_back(CH_MINUS);
                text.push_back(CH_PLUS);
            end
            4: begin
                // broken sign sequences end the literal early
                text.push_back($urandom_range(0, 1) ? CH_MINUS : CH_PLUS);
                text.push_back($urandom_range(0, 1) ? CH_MINUS : space_char());
            end
            default: ;
        endcase
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 5);
        case ($urandom_range(0, 2))
            0: begin
                text.push_back(CH_0);
                text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
                repeat (n) text.push_back(hexset[$urandom_range(0, 21)]);
            end
            1: begin
                text.push_back(CH_0);
                repeat (n) text.push_back(CH_0 + 8'($urandom_range(0, 7)));
            end
            default: begin
                text.push_back(CH_0 + 8'($urandom_range(1, 9)));
                repeat (n) text.push_back(CH_0 + 8'($urandom_range(0, 9)));
            end
        endcase
        case ($urandom_range(0, 3))
            0: text.push_back(8'($urandom_range(0, 255)));
            1: begin
                text.push_back(8'h00);
                text.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
    endtask

    initial begin
        int count;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_text("7");            send_literal();
        push_text("-123");         send_literal();
        push_text("+42");          send_literal();
        push_text("-+9");          send_literal();
        push_text("0x");           send_literal();
        push_text("0XaBcD");       send_literal();
        push_text("0xFFFFFFFF");   send_literal();
        push_text("-0x7fffffff");  send_literal();
        push_text("0777");         send_literal();
        push_text("089");          send_literal();
        push_text("0");            send_literal();
        push_text("- 5");          send_literal();
        push_text("--5");          send_literal();
        push_text("+-5");          send_literal();
        push_text("4294967297");   send_literal();
        push_text("2147483648");   send_literal();
        push_text("-2147483648");  send_literal();
        push_text("12x34");        send_literal();
        push_text("abc");          send_literal();
        push_text(" \t\n");
        text.push_back(8'd11);
        text.push_back(8'd12);
        text.push_back(8'd13);
        push_text("+77");          send_literal();
        // zero byte terminates the literal
        push_text("12");
        text.push_back(8'h00);
        push_text("34");           send_literal();
        text.push_back(8'hff);     send_literal();
        text.push_back(8'h80);     send_literal();

        count = 0;
        while (chars_sent < 1380) begin
            steady = (count >= 100 && count < 160);
            if (count == 40) begin
                // let the result stream drain completely
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (board.pending() != 0);
            end
            make_literal();
            send_literal();
            count++;
        end
        s_axis_tvalid <= 1'b0;

        do @(posedge i_clk); while (board.pending() != 0);
        repeat (8) @(posedge i_clk);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("** integer_literal_parser: PASSED **");
        end else begin
            $display("** integer_literal_parser: FAILED **");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("** integer_literal_parser: FAILED **");
        $finish;
    end

endmodule

FILE: files.f
rtl/ilp_pkg.sv
rtl/ilp_step.sv
rtl/integer_literal_parser.sv
tb/integer_literal_parser_tb.sv
